FILE: rtl/core/bba_pkg.sv
// Package of the buddy block allocator: pool geometry, field widths,
// operation and status codes, back-end state encoding and the command record.
// Depends on nothing; every other file of the core imports it.
package bba_pkg;

  localparam int unsigned POOL_LEVEL = 10;
  localparam int unsigned MIN_LEVEL  = 4;
  localparam int unsigned NUM_LEVELS = POOL_LEVEL - MIN_LEVEL + 1;
  localparam int unsigned NUM_UNITS  = 1 << (POOL_LEVEL - MIN_LEVEL);

  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned OFF_W    = POOL_LEVEL;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LVL_W    = $clog2(NUM_LEVELS);
  localparam int unsigned UNIT_W   = POOL_LEVEL - MIN_LEVEL;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(NUM_LEVELS - 1);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SEARCH,
    BS_SPLIT,
    BS_FLOOK,
    BS_MERGE,
    BS_DONE
  } back_state_e;

  // One classified request as it waits between the front and the back end.
  // The level is stored relative to MIN_LEVEL.
  typedef struct packed {
    mode_e              op;
    status_e            err;
    logic [LVL_W-1:0]   want;
    logic [UNIT_W-1:0]  unit;
  } cmd_t;

endpackage

FILE: rtl/core/bba_req_if.sv
// Request channel of the buddy block allocator: valid, ready and one request.
// Depends on bba_pkg for the field widths.
interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] size_bytes;
  logic [OFF_W-1:0]  address;

  modport source(output valid, mode, size_bytes, address, input ready);
  modport sink(input valid, mode, size_bytes, address, output ready);
endinterface

FILE: rtl/core/bba_rsp_if.sv
// Response channel of the buddy block allocator: valid, ready and one result.
// Depends on bba_pkg for the field widths.
interface bba_rsp_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    block_offset;
  logic [LEVEL_W-1:0]  block_level;

  modport source(output valid, status, block_offset, block_level, input ready);
  modport sink(input valid, status, block_offset, block_level, output ready);
endinterface

FILE: rtl/core/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: front end, command queue, back end.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_front, bba_cmd_queue, bba_back.
//
//   Channel  Dir  Handshake     Beat contents
//   req_i    in   valid/ready   mode, size_bytes, address
//   rsp_o    out  valid/ready   status, block_offset, block_level
//
// An allocate runs IDLE, a SEARCH step per level from the wanted one upward, a
// SPLIT step per split and DONE; a free runs IDLE, FLOOK, a MERGE step per merge
// plus a final one, and DONE. A request refused unsearched (oversized, misaligned
// or not allocated) runs IDLE, DONE. The sequencer walks one level per cycle.
// Reset frees the whole pool as one top-level block and clears every grant.
// A two-entry queue lets requests be taken while the back end works or a
// response waits; a stalled response stops the back end only at its last step.
module buddy_block_allocator_core import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t cmd;
  cmd_t head;

  // The front end decodes each request beat into a command: wanted level,
  // block unit and any error that needs no state (oversized request or a
  // misaligned free address).
  bba_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  // Commands wait here so that new beats are taken while the back end runs.
  bba_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The back end owns all allocator state and carries out one command at a
  // time, removing it from the queue when its response is registered.
  bba_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

  // An error response carries no block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |->
      rsp_o.block_offset == '0 && rsp_o.block_level == '0)
    else $error("error response with nonzero block fields");

  // A granted or merged block lies within the level range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_OK |->
      rsp_o.block_level >= LEVEL_W'(MIN_LEVEL) && rsp_o.block_level <= LEVEL_W'(POOL_LEVEL))
    else $error("block level out of range");

  // A block starts on a multiple of its own size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_OK |->
      (rsp_o.block_offset & ((OFF_W'(1) << rsp_o.block_level) - 1'b1)) == '0)
    else $error("block offset not aligned to its level");

  // The back end removes a command only when one is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("command removed from an empty queue");

endmodule

FILE: rtl/core/bba_front.sv
// Front end of the buddy block allocator: takes request beats and classifies them.
// Depends on bba_pkg and bba_req_if.
module bba_front import bba_pkg::*; (
  bba_req_if.sink req_i,
  input  logic    full_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  logic [LVL_W-1:0] want;
  logic             too_large;
  logic             misaligned;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  // The payload plus a one-byte header fits a block of 2^L bytes exactly
  // when size < 2^L, so the smallest such level is the wanted one.
  always_comb begin
    want = LVL_TOP;
    for (int r = NUM_LEVELS - 1; r >= 0; r--) begin
      if ({1'b0, req_i.size_bytes} < ((SIZE_W + 1)'(1) << (r + MIN_LEVEL))) begin
        want = LVL_W'(r);
      end
    end
  end

  assign too_large  = {1'b0, req_i.size_bytes} >= ((SIZE_W + 1)'(1) << POOL_LEVEL);
  assign misaligned = req_i.address[MIN_LEVEL-1:0] != '0;

  always_comb begin
    cmd_o.op   = mode_e'(req_i.mode);
    cmd_o.want = want;
    cmd_o.unit = req_i.address[POOL_LEVEL-1:MIN_LEVEL];
    cmd_o.err  = ST_OK;
    if (req_i.mode == MODE_ALLOC) begin
      if (too_large) cmd_o.err = ST_TOO_LARGE;
    end else begin
      if (misaligned) cmd_o.err = ST_BAD_FREE;
    end
  end

endmodule

FILE: rtl/core/bba_cmd_queue.sv
// Two-entry command queue that decouples the front end from the back end.
// Depends on bba_pkg for the command record.
module bba_cmd_queue import bba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o       = cnt_q == QCNT_W'(QDEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = wr_ptr_q + 1'b1;
    if (do_pop) rd_ptr_d = rd_ptr_q + 1'b1;
    if (push_i && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!push_i && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

FILE: rtl/core/bba_back.sv
// Back end of the buddy block allocator: free bitmaps, level table, the
// split and merge sequencer and the response register.
// Depends on bba_pkg and bba_rsp_if.
module bba_back import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     head_valid_i,
  input  cmd_t     head_i,
  output logic     pop_o,
  bba_rsp_if.source rsp_o
);

  // Free flags per level (relative level index), one bit per block.
  logic [NUM_UNITS-1:0] free_map_q [NUM_LEVELS];
  logic [NUM_UNITS-1:0] alloc_valid_q;
  logic [LVL_W-1:0]     level_mem [NUM_UNITS];
  logic [LVL_W-1:0]     lvl_rd_q;

  back_state_e      state_q, state_d;
  logic [LVL_W-1:0] lev_q, lev_d;
  logic [OFF_W-1:0] off_q, off_d;

  status_e            res_status_q, res_status_d;
  logic [OFF_W-1:0]   res_off_q, res_off_d;
  logic [LEVEL_W-1:0] res_lvl_q, res_lvl_d;

  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [OFF_W-1:0]   out_off_q;
  logic [LEVEL_W-1:0] out_lvl_q;
  logic               out_load;

  logic                 fm_we;
  logic [LVL_W-1:0]     fm_lvl;
  logic [UNIT_W-1:0]    fm_idx;
  logic                 fm_val;
  logic                 av_we;
  logic                 av_val;
  logic [UNIT_W-1:0]    av_idx;
  logic                 mem_we;
  logic [UNIT_W-1:0]    mem_addr;

  logic [NUM_UNITS-1:0] row;
  logic [LEVEL_W-1:0]   abs_lvl;
  logic [LEVEL_W-1:0]   abs_below;
  logic [UNIT_W-1:0]    low_idx;
  logic [OFF_W-1:0]     found_off;
  logic [UNIT_W-1:0]    cur_idx;
  logic [UNIT_W-1:0]    buddy_idx;
  logic [UNIT_W-1:0]    upper_idx;

  function automatic logic [UNIT_W-1:0] lowest_set(logic [NUM_UNITS-1:0] v);
    logic [UNIT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_UNITS - 1; i >= 0; i--) begin
      if (v[i]) idx = UNIT_W'(i);
    end
    return idx;
  endfunction

  assign row       = free_map_q[lev_q];
  assign abs_lvl   = LEVEL_W'(lev_q) + LEVEL_W'(MIN_LEVEL);
  assign abs_below = abs_lvl - 1'b1;
  assign low_idx   = lowest_set(row);
  assign found_off = OFF_W'(low_idx) << abs_lvl;
  assign cur_idx   = UNIT_W'(off_q >> abs_lvl);
  assign buddy_idx = cur_idx ^ UNIT_W'(1);
  assign upper_idx = UNIT_W'(off_q >> abs_below) | UNIT_W'(1);

  assign out_load = (state_q == BS_DONE) && (!out_valid_q || rsp_o.ready);
  assign pop_o    = out_load;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (head_valid_i) begin
          if (head_i.err != ST_OK) state_d = BS_DONE;
          else if (head_i.op == MODE_ALLOC) state_d = BS_SEARCH;
          else if (!alloc_valid_q[head_i.unit]) state_d = BS_DONE;
          else state_d = BS_FLOOK;
        end
      end
      BS_SEARCH: begin
        if (row != '0) begin
          state_d = (lev_q == head_i.want) ? BS_DONE : BS_SPLIT;
        end else if (lev_q == LVL_TOP) begin
          state_d = BS_DONE;
        end
      end
      BS_SPLIT: begin
        if (lev_q - 1'b1 == head_i.want) state_d = BS_DONE;
      end
      BS_FLOOK: state_d = BS_MERGE;
      BS_MERGE: begin
        if (!(lev_q != LVL_TOP && row[buddy_idx])) state_d = BS_DONE;
      end
      BS_DONE: begin
        if (out_load) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // Datapath controls and result capture.
  always_comb begin
    lev_d        = lev_q;
    off_d        = off_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_lvl_d    = res_lvl_q;
    fm_we        = 1'b0;
    fm_lvl       = lev_q;
    fm_idx       = cur_idx;
    fm_val       = 1'b0;
    av_we        = 1'b0;
    av_val       = 1'b0;
    av_idx       = head_i.unit;
    mem_we       = 1'b0;
    mem_addr     = off_q[OFF_W-1:MIN_LEVEL];
    unique case (state_q)
      BS_IDLE: begin
        res_status_d = head_i.err;
        res_off_d    = '0;
        res_lvl_d    = '0;
        lev_d        = head_i.want;
        off_d        = OFF_W'(head_i.unit) << MIN_LEVEL;
        if (head_valid_i && head_i.err == ST_OK && head_i.op == MODE_FREE) begin
          if (alloc_valid_q[head_i.unit]) begin
            av_we = 1'b1;
          end else begin
            res_status_d = ST_BAD_FREE;
          end
        end
      end
      BS_SEARCH: begin
        if (row != '0) begin
          fm_we  = 1'b1;
          fm_idx = low_idx;
          off_d  = found_off;
          if (lev_q == head_i.want) begin
            mem_we       = 1'b1;
            mem_addr     = found_off[OFF_W-1:MIN_LEVEL];
            av_we        = 1'b1;
            av_val       = 1'b1;
            av_idx       = found_off[OFF_W-1:MIN_LEVEL];
            res_status_d = ST_OK;
            res_off_d    = found_off;
            res_lvl_d    = abs_lvl;
          end
        end else if (lev_q == LVL_TOP) begin
          res_status_d = ST_NO_FREE;
        end else begin
          lev_d = lev_q + 1'b1;
        end
      end
      BS_SPLIT: begin
        fm_we  = 1'b1;
        fm_lvl = lev_q - 1'b1;
        fm_idx = upper_idx;
        fm_val = 1'b1;
        lev_d  = lev_q - 1'b1;
        if (lev_q - 1'b1 == head_i.want) begin
          mem_we       = 1'b1;
          av_we        = 1'b1;
          av_val       = 1'b1;
          av_idx       = off_q[OFF_W-1:MIN_LEVEL];
          res_status_d = ST_OK;
          res_off_d    = off_q;
          res_lvl_d    = abs_below;
        end
      end
      BS_FLOOK: lev_d = lvl_rd_q;
      BS_MERGE: begin
        fm_we = 1'b1;
        if (lev_q != LVL_TOP && row[buddy_idx]) begin
          fm_idx = buddy_idx;
          off_d  = off_q & ~(OFF_W'(1) << abs_lvl);
          lev_d  = lev_q + 1'b1;
        end else begin
          fm_val       = 1'b1;
          res_status_d = ST_OK;
          res_off_d    = off_q;
          res_lvl_d    = abs_lvl;
        end
      end
      BS_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BS_IDLE;
      out_valid_q   <= 1'b0;
      alloc_valid_q <= '0;
      // Only the whole pool is free: one block at the top level.
      for (int l = 0; l < NUM_LEVELS; l++) begin
        free_map_q[l] <= (l == int'(LVL_TOP)) ? NUM_UNITS'(1) : NUM_UNITS'(0);
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fm_we) free_map_q[fm_lvl][fm_idx] <= fm_val;
      if (av_we) alloc_valid_q[av_idx] <= av_val;
    end
  end

  always_ff @(posedge clk_i) begin
    lev_q        <= lev_d;
    off_q        <= off_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_lvl_q    <= res_lvl_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_lvl_q    <= res_lvl_q;
    end
  end

  // Level table: one write port, one registered read port at the head's unit.
  always_ff @(posedge clk_i) begin
    if (mem_we) level_mem[mem_addr] <= head_i.want;
    lvl_rd_q <= level_mem[head_i.unit];
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.block_offset = out_off_q;
  assign rsp_o.block_level  = out_lvl_q;

endmodule
